// ----- src/positional_insert_remove_queue_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the positional insert/remove queue
// Each macro checks a property on clk. With ASSERT_OFF defined, the macros
// expand to nothing.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_REMOVE_QUEUE_CORE_DEFINES_SVH
`define POSITIONAL_INSERT_REMOVE_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// This check is suspended while arst_n is low.
`define PIRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// This check also holds while reset is asserted.
`define PIRQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PIRQ_ASSERT(lbl, prop, msg)
`define PIRQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- src/pirq_pkg.sv -----
// ----------------------------------------------------------------------------
// pirq_pkg
// Operation codes, status codes, field widths and the command that is
// broadcast to every storage cell of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pirq_pkg;

	localparam int FUNC_W = 3;
	localparam int POS_W  = 16;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	localparam logic [FUNC_W-1:0] FN_ENQ = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DEQ = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REM = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLR = 3'd4;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	// Command seen by all cells in the same cycle.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [POS_W-1:0] at;
		logic [VAL_W-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- src/pirq_cell.sv -----
// ----------------------------------------------------------------------------
// pirq_cell
// One storage cell of the queue. On an insert it loads the new value at the
// insert point or takes its left neighbor's value behind it; on a remove it
// takes its right neighbor's value from the removal point on.
// ----------------------------------------------------------------------------
`default_nettype none

module pirq_cell #(
	parameter int IDX = 0
) (
	input  wire                          clk,
	input  pirq_pkg::cell_cmd_t          cmd,
	input  wire  [pirq_pkg::VAL_W-1:0]   left_data,
	input  wire  [pirq_pkg::VAL_W-1:0]   right_data,
	output logic [pirq_pkg::VAL_W-1:0]   data
);
	import pirq_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic [VAL_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX == cmd.at) begin
				data_q <= cmd.value;
			end else if (MY_IDX > cmd.at) begin
				data_q <= left_data;
			end
		end else if (cmd.rem) begin
			if (MY_IDX >= cmd.at) begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ----- src/pirq_ctrl.sv -----
// ----------------------------------------------------------------------------
// pirq_ctrl
// Decodes one operation against the entry count, keeps the count, and
// builds the shift command for the cell row and the result status.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_insert_remove_queue_core_defines.svh"

module pirq_ctrl #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            fire,
	input  wire  [pirq_pkg::FUNC_W-1:0]    func,
	input  wire  [pirq_pkg::POS_W-1:0]     position,
	input  wire  [pirq_pkg::VAL_W-1:0]     entry_value,
	output pirq_pkg::cell_cmd_t            cmd,
	output logic                           take_front,
	output logic [pirq_pkg::STAT_W-1:0]    status,
	output logic [pirq_pkg::OCC_W-1:0]     occupancy
);
	import pirq_pkg::*;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic [POS_W-1:0] cnt_pos;
	logic [POS_W-1:0] ins_at;
	logic             pos_neg;
	logic             full;
	logic             empty;
	logic             do_ins;
	logic             do_rem;
	logic [POS_W-1:0] at;

	assign cnt_pos = POS_W'(count_q);
	assign pos_neg = position[POS_W-1];
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);

	// A negative position goes to the front, a position past the end is
	// clamped to the count.
	assign ins_at = pos_neg ? '0 : ((position > cnt_pos) ? cnt_pos : position);

	always_comb begin
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		at         = '0;
		take_front = 1'b0;
		status     = ST_DONE;
		count_d    = count_q;
		unique case (func)
			FN_ENQ: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					at      = cnt_pos;
					count_d = count_q + 1'b1;
				end
			end
			FN_DEQ: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					do_rem     = 1'b1;
					take_front = 1'b1;
					count_d    = count_q - 1'b1;
				end
			end
			FN_INS: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					at      = ins_at;
					count_d = count_q + 1'b1;
				end
			end
			FN_REM: begin
				if (pos_neg || position >= cnt_pos) begin
					status = ST_RANGE;
				end else begin
					do_rem  = 1'b1;
					at      = position;
					count_d = count_q - 1'b1;
				end
			end
			FN_CLR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign cmd.ins   = fire & do_ins;
	assign cmd.rem   = fire & do_rem;
	assign cmd.at    = at;
	assign cmd.value = entry_value;

	assign occupancy = OCC_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_d;
		end
	end

	`PIRQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
	`PIRQ_ASSERT(a_one_shift, !(cmd.ins && cmd.rem), "insert and remove in one cycle")
	`PIRQ_ASSERT(a_clear_empties, fire && func == FN_CLR |=> count_q == '0, "clear left entries")
	`PIRQ_ASSERT(a_full_holds, fire && status == ST_FULL |=> $stable(count_q), "full reject moved count")

endmodule

`default_nettype wire

// ----- src/positional_insert_remove_queue_core.sv -----
// ----------------------------------------------------------------------------
// positional_insert_remove_queue_core
// Bounded ordered queue of signed 32-bit values with enqueue, dequeue,
// insert and remove at a position, and clear, built as a row of cells.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata fields (low bit first)
//  s_axis   | in        | func[2:0], position[18:3], entry_value[50:19]
//  m_axis   | out       | result_value[31:0], status[33:32], occupancy[38:34]
//
// All cells shift in parallel in the cycle an item is accepted, so an insert
// or remove at any position costs the same.
// The result sits in an output register; a new item is accepted whenever
// that register is empty or is being drained in the same cycle.
// Reset clears the entry count and the output valid; cell contents are not
// cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_remove_queue_core #(
	parameter int DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [55:0] s_axis_tdata,  // func, position, entry_value, zero pad
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata   // result_value, status, occupancy
);
	import pirq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int OUT_W = VAL_W + STAT_W + OCC_W;

	logic                fire;
	logic [FUNC_W-1:0]   func;
	logic [POS_W-1:0]    position;
	logic [VAL_W-1:0]    entry_value;
	cell_cmd_t           cmd;
	logic                take_front;
	logic [STAT_W-1:0]   status;
	logic [OCC_W-1:0]    occupancy;
	logic [VAL_W-1:0]    cell_data [DEPTH];
	logic [VAL_W-1:0]    result_value;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	assign func        = s_axis_tdata[FUNC_W-1:0];
	assign position    = s_axis_tdata[FUNC_W +: POS_W];
	assign entry_value = s_axis_tdata[FUNC_W+POS_W +: VAL_W];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign fire          = s_axis_tvalid && s_axis_tready;

	pirq_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.func        (func),
		.position    (position),
		.entry_value (entry_value),
		.cmd         (cmd),
		.take_front  (take_front),
		.status      (status),
		.occupancy   (occupancy)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_data;
		logic [VAL_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_inner_l
			assign left_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_inner_r
			assign right_data = cell_data[i+1];
		end

		pirq_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i])
		);
	end

	// The front cell still holds the dequeued value during the accept cycle.
	assign result_value = take_front ? cell_data[0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {occupancy, status, result_value};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(40 - OUT_W){1'b0}}, out_data_q};

endmodule

`default_nettype wire
